// ----- src/bdd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bdd_pkg - shared constants, types and helpers
// Sizes, register indexes and disc geometry for the binary disc denoise filter.
// ----------------------------------------------------------------------------
package bdd_pkg;

	localparam int MAX_SIZE   = 2048;
	localparam int SIZE_CFG_W = 12;
	localparam int THR_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	localparam int REACH   = 3;
	localparam int WIN     = 2 * REACH + 1;
	localparam int LB_W    = WIN - 1;
	localparam int DISC_R2 = 10;

	localparam int SZ_W      = $clog2(MAX_SIZE + 1);
	localparam int COL_W     = $clog2(MAX_SIZE);
	localparam int CNT_W     = $clog2(MAX_SIZE * MAX_SIZE + REACH * MAX_SIZE + REACH + 1);
	localparam int LAG_W     = $clog2(REACH * MAX_SIZE + REACH + 1);
	localparam int CNT_COL_W = $clog2(WIN + 1);
	localparam int SUM_W     = $clog2(WIN * WIN + 1);

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_THRESHOLD = CFG_IDX_W'(1);

	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	localparam logic [SIZE_CFG_W-1:0] SIZE_RST = SIZE_CFG_W'(2048);
	localparam logic [THR_W-1:0]      THR_RST  = THR_W'(20);

	typedef logic [WIN-1:0] col_t;

	typedef struct packed {
		logic pixel_out;
		logic frame_last;
	} res_t;

	typedef struct packed {
		logic shift;
		logic centre;
		col_t row_ok;
	} cell_ctl_t;

	// rows of window column d that fall inside the disc
	function automatic col_t disc_mask(input int d);
		col_t mask;
		int   dm;
		int   dl;
		mask = '0;
		dl   = d - REACH;
		for (int m = 0; m < WIN; m++) begin
			dm      = m - REACH;
			mask[m] = (dm * dm + dl * dl) <= DISC_R2;
		end
		return mask;
	endfunction

	function automatic logic [SZ_W-1:0] clamp_size(input logic [SIZE_CFG_W-1:0] s);
		logic [SZ_W-1:0] r;
		if (s == '0) begin
			r = SZ_W'(1);
		end else if (int'(s) > MAX_SIZE) begin
			r = SZ_W'(MAX_SIZE);
		end else begin
			r = SZ_W'(s);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- src/bdd_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bdd_if - channel interfaces
// Pixel input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface bdd_pix_if;
	logic valid;
	logic ready;
	logic action;
	logic pixel_in;

	modport source(output valid, output action, output pixel_in, input ready);
	modport sink(input valid, input action, input pixel_in, output ready);
endinterface

interface bdd_res_if;
	logic valid;
	logic ready;
	logic pixel_out;
	logic frame_last;

	modport source(output valid, output pixel_out, output frame_last, input ready);
	modport sink(input valid, input pixel_out, input frame_last, output ready);
endinterface

interface bdd_cfg_if import bdd_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- src/bdd_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bdd_ram - generic single-port-write RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bdd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ----- src/bdd_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bdd_cell - one window column
// Holds a 7-pixel column, passes it on each shift and counts the pixels of
// the column that lie in the disc, inside the image and differ from centre.
// ----------------------------------------------------------------------------
module bdd_cell import bdd_pkg::*; (
	input  wire logic                 clk,
	input  wire cell_ctl_t            ctl,
	input  wire col_t                 disc,
	input  wire logic                 col_ok,
	input  wire col_t                 col_in,
	output col_t                      col_out,
	output logic [CNT_COL_W-1:0]      diff_s3
);

	col_t                 col_q;
	col_t                 hits;
	logic [CNT_COL_W-1:0] n_diff;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			col_q <= col_in;
		end
	end

	assign hits = (col_q ^ {WIN{ctl.centre}}) & disc & ctl.row_ok & {WIN{col_ok}};

	always_comb begin
		n_diff = '0;
		for (int m = 0; m < WIN; m++) begin
			n_diff = n_diff + CNT_COL_W'(hits[m]);
		end
	end

	always_ff @(posedge clk) begin
		diff_s3 <= n_diff;
	end

	assign col_out = col_q;

endmodule
`default_nettype wire

// ----- src/binary_disc_denoise_filter_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// binary_disc_denoise_filter_unit - streaming binary disc denoise filter
// Flips a pixel when enough in-image disc neighbours differ from it.
//
// pix: one word per pixel in raster order (action 0) or a flush tick
//   (action 1). A new word can be taken every cycle while pix.ready is high.
//   The result for pixel p is caused by the word carrying pixel p+3n+3
//   (n = side length), or by a flush once the frame is complete;
//   frame_last marks the final result. res: results, from s3 via the queue.
// cfg: register writes (0 image_size, 1 flip_threshold), always ready.
//   image_size is sampled on the first pixel of a frame.
// Throughput is one word per cycle while pix is not held off, set by the
// single line-buffer RAM port pair and the 7-cell window chain. For sides
// of 3 or less the block primes the window after the last pixel and takes
// no words meanwhile.
// An 8-word result queue decouples res; when the receiver stalls, pix is
// held off once the queue and the words in flight would fill it.
// After reset the line buffers hold junk; rows above the frame are masked,
// so no clearing pass is needed and words are taken at once.
// ----------------------------------------------------------------------------
module binary_disc_denoise_filter_unit import bdd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bdd_cfg_if.sink    cfg,
	bdd_pix_if.sink    pix,
	bdd_res_if.source  res
);

	localparam int RW = SZ_W + 1;

	// configuration
	logic [SIZE_CFG_W-1:0] img_size_q;
	logic [THR_W-1:0]      thr_q;

	// frame control
	logic [SZ_W-1:0]  size_q;
	logic [CNT_W-1:0] total_q;
	logic [LAG_W-1:0] lag_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] out_q;
	logic [CNT_W-1:0] adv_q;
	logic [COL_W-1:0] col_q;
	logic [COL_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;

	logic             complete;
	logic             silent;
	logic             space;
	logic             acc;
	logic             storing;
	logic             drain_emit;
	logic             frame_start;
	logic             adv;
	logic             emit;
	logic             last;
	logic [SZ_W-1:0]  size_new;
	logic [SZ_W-1:0]  size_eff;
	logic [2*SZ_W-1:0] sq_new;
	logic [LAG_W-1:0] lag_new;
	col_t             row_ok;
	col_t             col_ok;

	// pipeline
	logic             adv_s1, emit_s1, last_s1, px_s1, byp_s1;
	logic [COL_W-1:0] addr_s1;
	logic [LB_W-1:0]  byp_data_s1;
	col_t             rowok_s1, colok_s1;
	logic             emit_s2, last_s2;
	col_t             rowok_s2, colok_s2;
	logic             emit_s3, last_s3, centre_s3;

	logic [LB_W-1:0]  ram_rd;
	logic [LB_W-1:0]  rd_eff;
	col_t             col_vec;
	logic [LB_W-1:0]  wr_data;

	col_t                 win  [WIN];
	logic [CNT_COL_W-1:0] diff [WIN];
	cell_ctl_t            cell_ctl;
	logic [SUM_W-1:0]     sum;
	logic                 flip;

	// result queue
	res_t               fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FCNT_W-1:0]  fifo_cnt_q;
	logic               push, pop;

	// ---------------- configuration ----------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_size_q <= SIZE_RST;
			thr_q      <= THR_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_IMAGE_SIZE:     img_size_q <= cfg.data[SIZE_CFG_W-1:0];
				REG_FLIP_THRESHOLD: thr_q      <= cfg.data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- front control ----------------
	assign complete = (cnt_q != '0) && (cnt_q == total_q);
	assign silent   = complete && (adv_q < CNT_W'(lag_q));
	assign space    = ((FCNT_W+1)'(fifo_cnt_q) + (FCNT_W+1)'(emit_s1) + (FCNT_W+1)'(emit_s2)
	                  + (FCNT_W+1)'(emit_s3)) < (FCNT_W+1)'(FIFO_DEPTH);

	assign pix.ready   = !silent && space;
	assign acc         = pix.valid && pix.ready;
	assign storing     = acc && (pix.action == ACT_PIXEL) && (cnt_q < total_q);
	assign drain_emit  = acc && complete;
	assign frame_start = storing && (cnt_q == '0);
	assign adv         = storing || drain_emit || silent;
	assign emit        = (storing && (cnt_q >= CNT_W'(lag_q))) || drain_emit;
	assign last        = emit && ((out_q + CNT_W'(1)) == total_q);

	assign size_new = clamp_size(img_size_q);
	assign size_eff = frame_start ? size_new : size_q;
	assign sq_new   = size_new * size_new;
	assign lag_new  = LAG_W'(size_new) * LAG_W'(REACH) + LAG_W'(REACH);

	// image-edge masks for the centre pixel out_q
	always_comb begin
		for (int m = 0; m < WIN; m++) begin
			if (m < REACH) begin
				row_ok[m] = (RW'(out_row_q) + RW'(REACH - m)) < RW'(size_q);
				col_ok[m] = (RW'(out_col_q) + RW'(REACH - m)) < RW'(size_q);
			end else if (m > REACH) begin
				row_ok[m] = out_row_q >= COL_W'(m - REACH);
				col_ok[m] = out_col_q >= COL_W'(m - REACH);
			end else begin
				row_ok[m] = 1'b1;
				col_ok[m] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= SZ_W'(1);
			total_q   <= CNT_W'(1);
			lag_q     <= LAG_W'(2 * REACH);
			cnt_q     <= '0;
			out_q     <= '0;
			adv_q     <= '0;
			col_q     <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
		end else begin
			if (frame_start) begin
				size_q  <= size_new;
				total_q <= CNT_W'(sq_new);
				lag_q   <= lag_new;
			end
			if (storing) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (adv) begin
				adv_q <= adv_q + CNT_W'(1);
				col_q <= (col_q == COL_W'(size_eff - SZ_W'(1))) ? '0 : col_q + COL_W'(1);
			end
			if (emit) begin
				out_q <= out_q + CNT_W'(1);
				if (out_col_q == COL_W'(size_q - SZ_W'(1))) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + COL_W'(1);
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
			if (last) begin
				cnt_q     <= '0;
				out_q     <= '0;
				adv_q     <= '0;
				col_q     <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
			end
		end
	end

	// ---------------- line buffers ----------------
	bdd_ram #(
		.WIDTH(LB_W),
		.DEPTH(MAX_SIZE)
	) u_lb (
		.clk     (clk),
		.wr_en   (adv_s1),
		.wr_addr (addr_s1),
		.wr_data (wr_data),
		.rd_en   (adv),
		.rd_addr (col_q),
		.rd_data (ram_rd)
	);

	// bit m of the column is the pixel m rows up
	assign rd_eff  = byp_s1 ? byp_data_s1 : ram_rd;
	assign col_vec = {rd_eff, px_s1};
	assign wr_data = col_vec[LB_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adv_s1  <= 1'b0;
			emit_s1 <= 1'b0;
			byp_s1  <= 1'b0;
			emit_s2 <= 1'b0;
			emit_s3 <= 1'b0;
		end else begin
			adv_s1  <= adv;
			emit_s1 <= emit;
			byp_s1  <= adv && adv_s1 && (col_q == addr_s1);
			emit_s2 <= emit_s1;
			emit_s3 <= emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		px_s1       <= storing && pix.pixel_in;
		addr_s1     <= col_q;
		last_s1     <= last;
		rowok_s1    <= row_ok;
		colok_s1    <= col_ok;
		byp_data_s1 <= wr_data;
		last_s2     <= last_s1;
		rowok_s2    <= rowok_s1;
		colok_s2    <= colok_s1;
		last_s3     <= last_s2;
		centre_s3   <= win[REACH][REACH];
	end

	// ---------------- window chain ----------------
	assign cell_ctl.shift  = adv_s1;
	assign cell_ctl.centre = win[REACH][REACH];
	assign cell_ctl.row_ok = rowok_s2;

	for (genvar d = 0; d < WIN; d++) begin : g_cell
		if (d == 0) begin : g_head
			bdd_cell u_cell (
				.clk     (clk),
				.ctl     (cell_ctl),
				.disc    (disc_mask(d)),
				.col_ok  (colok_s2[d]),
				.col_in  (col_vec),
				.col_out (win[d]),
				.diff_s3 (diff[d])
			);
		end else begin : g_body
			bdd_cell u_cell (
				.clk     (clk),
				.ctl     (cell_ctl),
				.disc    (disc_mask(d)),
				.col_ok  (colok_s2[d]),
				.col_in  (win[d-1]),
				.col_out (win[d]),
				.diff_s3 (diff[d])
			);
		end
	end

	always_comb begin
		sum = '0;
		for (int d = 0; d < WIN; d++) begin
			sum = sum + SUM_W'(diff[d]);
		end
	end

	assign flip = (SUM_W+THR_W)'(sum) >= (SUM_W+THR_W)'(thr_q);

	// ---------------- result queue ----------------
	assign push = emit_s3;
	assign pop  = res.valid && res.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= '{pixel_out: centre_s3 ^ flip, frame_last: last_s3};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			fifo_cnt_q <= fifo_cnt_q + FCNT_W'(push) - FCNT_W'(pop);
		end
	end

	assign res.valid      = fifo_cnt_q != '0;
	assign res.pixel_out  = fifo_q[rd_ptr_q].pixel_out;
	assign res.frame_last = fifo_q[rd_ptr_q].frame_last;

	// ---------------- assertions ----------------
	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> fifo_cnt_q < FCNT_W'(FIFO_DEPTH))
		else $error("result queue overrun");

	a_emit_align: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> adv_q == out_q + CNT_W'(lag_q))
		else $error("window position does not match output position");

	a_out_behind: assert property (@(posedge clk) disable iff (!arst_n)
		out_q <= cnt_q)
		else $error("output count ahead of input count");

endmodule
`default_nettype wire

// ----- tb/binary_disc_denoise_filter_unit_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// binary_disc_denoise_filter_unit_tb - self-checking bench for the disc filter
// Streams small binary frames with flush ticks through the pixel channel and
// rewrites size and threshold between frames and mid-frame. A predictor
// models the disc count, the size latch and the drain, and every result word
// is compared against it. Both channels idle at random; the result side also
// holds off for one long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module binary_disc_denoise_filter_unit_tb import bdd_pkg::*;;

	localparam int STORE_DEPTH   = 8 * MAX_SIZE;
	localparam int RANDOM_WORDS  = 1150;
	localparam int IDLE_PCT      = 37;
	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_LIMIT   = 2000;
	localparam int HOLD_AFTER    = 600;
	localparam int HOLD_CYCLES   = 150;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic action;
		logic pixel_in;
	} pix_word_t;

	logic clk = 1'b0;
	logic arst_n;

	always #5 clk = ~clk;

	bdd_pix_if pix_ch();
	bdd_res_if res_ch();
	bdd_cfg_if cfg_ch();

	binary_disc_denoise_filter_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.pix    (pix_ch),
		.res    (res_ch)
	);

	// predictor state
	bit                    pixel_store [STORE_DEPTH];
	int                    pix_count;
	int                    emit_count;
	int                    frame_side;
	logic [SIZE_CFG_W-1:0] size_reg;
	logic [THR_W-1:0]      thr_reg;

	pix_word_t pending_words [$];
	res_t      expected_pixels [$];
	pix_word_t offered;
	res_t      predicted;

	int words_pushed = 0;
	int words_taken  = 0;
	int results_seen = 0;
	int frames_done  = 0;
	int mismatches   = 0;
	int reg_writes   = 0;
	int stall_cycles = 0;
	int src_idle_pct = IDLE_PCT;
	int snk_idle_pct = IDLE_PCT;
	int hold_left    = 0;
	bit hold_done    = 1'b0;

	function automatic logic disc_pixel(input int pos);
		int   r0;
		int   c0;
		int   r;
		int   c;
		int   diff;
		logic centre;
		r0     = pos / frame_side;
		c0     = pos % frame_side;
		centre = pixel_store[pos % STORE_DEPTH];
		diff   = 0;
		for (int k = -REACH; k <= REACH; k++) begin
			for (int l = -REACH; l <= REACH; l++) begin
				r = r0 + k;
				c = c0 + l;
				if (r >= 0 && r < frame_side && c >= 0 && c < frame_side &&
						k * k + l * l <= DISC_R2) begin
					if (pixel_store[(r * frame_side + c) % STORE_DEPTH] != centre)
						diff++;
				end
			end
		end
		if (diff >= int'(thr_reg))
			centre = ~centre;
		return centre;
	endfunction

	function automatic logic denoise_step(input pix_word_t w, output res_t r);
		int   total;
		int   lag;
		logic fire;
		r    = '0;
		fire = 1'b0;
		if (w.action == ACT_PIXEL && pix_count == 0 && emit_count == 0) begin
			if (size_reg == '0)
				frame_side = 1;
			else if (int'(size_reg) > MAX_SIZE)
				frame_side = MAX_SIZE;
			else
				frame_side = int'(size_reg);
		end
		total = frame_side * frame_side;
		lag   = REACH * frame_side + REACH;
		if (w.action == ACT_PIXEL && pix_count < total) begin
			pixel_store[pix_count % STORE_DEPTH] = w.pixel_in;
			pix_count++;
			fire = (pix_count - emit_count > lag);
		end else begin
			fire = (pix_count > 0 && pix_count == total && emit_count < pix_count);
		end
		if (fire) begin
			r.pixel_out = disc_pixel(emit_count);
			emit_count++;
			if (emit_count >= total) begin
				r.frame_last = 1'b1;
				pix_count    = 0;
				emit_count   = 0;
			end
		end
		return fire;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_threshold();
		logic [CFG_DATA_W-1:0] v;
		int                    r;
		r = $urandom_range(99);
		if (r < 5)
			v = CFG_DATA_W'(0);
		else if (r < 10)
			v = CFG_DATA_W'(36);
		else if (r < 13)
			v = CFG_DATA_W'(37);
		else if (r < 16)
			v = CFG_DATA_W'(63);
		else
			v = CFG_DATA_W'($urandom_range(6, 28));
		if ($urandom_range(3) == 0)
			v[CFG_DATA_W-1:THR_W] = (CFG_DATA_W - THR_W)'($urandom_range(63));
		return v;
	endfunction

	task automatic push_word(input logic act, input logic px);
		pix_word_t w;
		w.action   = act;
		w.pixel_in = px;
		pending_words.push_back(w);
		words_pushed++;
	endtask

	task automatic wait_idle();
		while (words_taken != words_pushed || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// called just after a rising edge; returns once the write has been taken
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == REG_IMAGE_SIZE)
			size_reg = val[SIZE_CFG_W-1:0];
		else if (idx == REG_FLIP_THRESHOLD)
			thr_reg = val[THR_W-1:0];
		reg_writes++;
		@(posedge clk);
	endtask

	// pixel driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_ch.valid    <= 1'b0;
			pix_ch.action   <= ACT_FLUSH;
			pix_ch.pixel_in <= 1'b0;
		end else begin
			if (pix_ch.valid && pix_ch.ready) begin
				if (denoise_step(offered, predicted))
					expected_pixels.push_back(predicted);
				words_taken <= words_taken + 1;
			end
			if (!pix_ch.valid || pix_ch.ready) begin
				if (pending_words.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					offered = pending_words.pop_front();
					pix_ch.valid    <= 1'b1;
					pix_ch.action   <= offered.action;
					pix_ch.pixel_in <= offered.pixel_in;
				end else begin
					pix_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				got.pixel_out  = res_ch.pixel_out;
				got.frame_last = res_ch.frame_last;
				if (expected_pixels.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result %0d: none expected, got pixel_out=%b frame_last=%b",
							results_seen, got.pixel_out, got.frame_last);
				end else begin
					want = expected_pixels.pop_front();
					if (got.pixel_out !== want.pixel_out || got.frame_last !== want.frame_last) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("result %0d: expected pixel_out=%b frame_last=%b, got %b %b",
								results_seen, want.pixel_out, want.frame_last,
								got.pixel_out, got.frame_last);
					end
				end
				if (got.frame_last === 1'b1)
					frames_done++;
				results_seen++;
			end
			// one long hold-off so the result queue fills and pix backs up
			if (!hold_done && words_taken >= HOLD_AFTER) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	// watchdog on cycles with no word moving anywhere
	always @(posedge clk) begin
		if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles, %0d of %0d words taken, %0d pending",
				stall_cycles, words_taken, words_pushed, expected_pixels.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int side;
		int total;
		int lag;
		int split;
		int drain;
		int density;
		int frame_no;
		int random_words;
		int r;
		arst_n          = 1'b0;
		pix_ch.valid    = 1'b0;
		pix_ch.action   = ACT_FLUSH;
		pix_ch.pixel_in = 1'b0;
		res_ch.ready    = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = REG_IMAGE_SIZE;
		cfg_ch.data     = '0;
		for (int i = 0; i < STORE_DEPTH; i++)
			pixel_store[i] = 1'b0;
		pix_count  = 0;
		emit_count = 0;
		frame_side = 1;
		size_reg   = SIZE_RST;
		thr_reg    = THR_RST;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// flush with nothing pending
		@(negedge clk);
		push_word(ACT_FLUSH, 1'b1);
		wait_idle();

		// size 0 taken as 1, threshold 0 flips everything
		write_reg(REG_IMAGE_SIZE, '0);
		write_reg(REG_FLIP_THRESHOLD, '0);
		@(negedge clk);
		push_word(ACT_PIXEL, 1'b1);
		push_word(ACT_FLUSH, 1'b0);
		push_word(ACT_FLUSH, 1'b0);
		wait_idle();

		// 2x2 frame: early flush, pixel while draining, live threshold change
		write_reg(REG_IMAGE_SIZE, CFG_DATA_W'(2));
		write_reg(REG_FLIP_THRESHOLD, '1);
		@(negedge clk);
		push_word(ACT_PIXEL, 1'b0);
		push_word(ACT_FLUSH, 1'b1);
		push_word(ACT_PIXEL, 1'b1);
		push_word(ACT_PIXEL, 1'b1);
		push_word(ACT_PIXEL, 1'b0);
		push_word(ACT_PIXEL, 1'b1);
		push_word(ACT_FLUSH, 1'b0);
		wait_idle();
		write_reg(REG_FLIP_THRESHOLD, '0);
		@(negedge clk);
		push_word(ACT_FLUSH, 1'b0);
		push_word(ACT_FLUSH, 1'b1);
		push_word(ACT_FLUSH, 1'b0);
		wait_idle();

		// oversize and unused indexes, all overwritten before the next frame
		write_reg(REG_IMAGE_SIZE, '1);
		write_reg(REG_IMAGE_SIZE, CFG_DATA_W'(MAX_SIZE));
		write_reg(REG_FLIP_THRESHOLD + 1'b1, '1);
		write_reg(REG_FLIP_THRESHOLD + 2'd2, '0);

		frame_no     = 0;
		random_words = 0;
		while (random_words < RANDOM_WORDS) begin
			r = $urandom_range(99);
			if (r < 10)
				side = $urandom_range(1, 3);
			else if (r < 85)
				side = $urandom_range(4, 9);
			else
				side = $urandom_range(10, 16);
			if ($urandom_range(9) == 0)
				write_reg(REG_IMAGE_SIZE, CFG_DATA_W'($urandom_range(MAX_SIZE + 1, 4095)));
			if (side == 1 && $urandom_range(1) == 0)
				write_reg(REG_IMAGE_SIZE, '0);
			else
				write_reg(REG_IMAGE_SIZE, CFG_DATA_W'(side));
			if (frame_no == 0 || $urandom_range(2) == 0)
				write_reg(REG_FLIP_THRESHOLD, pick_threshold());
			total = side * side;
			lag   = REACH * side + REACH;
			r     = $urandom_range(2);
			density = (r == 0) ? 10 : (r == 1) ? 50 : 90;
			split = ($urandom_range(3) == 0 && total > 1) ? $urandom_range(1, total - 1) : total;
			@(negedge clk);
			src_idle_pct = (frame_no >= 4 && frame_no < 7) ? 0 : IDLE_PCT;
			snk_idle_pct = src_idle_pct;
			for (int p = 0; p < total; p++) begin
				if (p == split) begin
					// mid-frame: threshold acts at once, size only next frame
					wait_idle();
					write_reg(REG_FLIP_THRESHOLD, pick_threshold());
					write_reg(REG_IMAGE_SIZE, CFG_DATA_W'($urandom_range(4095)));
					@(negedge clk);
				end
				if ($urandom_range(99) < 4)
					push_word(ACT_FLUSH, 1'($urandom_range(1)));
				push_word(ACT_PIXEL, ($urandom_range(99) < density));
			end
			drain = (total < lag) ? total : lag;
			for (int d = 0; d < drain; d++)
				push_word(($urandom_range(3) == 0) ? ACT_PIXEL : ACT_FLUSH,
					1'($urandom_range(1)));
			if ($urandom_range(2) == 0)
				push_word(ACT_FLUSH, 1'($urandom_range(1)));
			random_words += total + drain;
			wait_idle();
			frame_no++;
		end

		wait_idle();
		repeat (20) @(posedge clk);
		$display("%0d words sent over %0d random frames, %0d register writes",
			words_taken, frame_no, reg_writes);
		$display("%0d results checked, %0d frames closed, %0d mismatches, %0d left over",
			results_seen, frames_done, mismatches, expected_pixels.size());
		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
